[hw/rtl/mws_pkg.sv]
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants of the masked weighted 3x3 smoother.
// ----------------------------------------------------------------------------
package mws_pkg;

    localparam int POS_W    = 10;   // row and column fields of a result
    localparam int DIM_W    = 11;   // grid_cols and grid_rows registers
    localparam int SCALE_W  = 32;   // weight_scale register
    localparam int WEIGHT_W = 16;
    localparam int Q_SHIFT  = 16;   // ratio is Q16
    localparam int RATIO_W  = 17;   // ratio saturates at 1.0
    localparam int CNT_W    = 4;    // up to nine neighbours
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    localparam logic [DIM_W-1:0]   COLS_RESET  = 11'd64;
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 11'd64;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    // per-step control passed from the front to the back
    typedef struct packed {
        logic point;    // carries a new grid point
        logic good;
        logic emit;     // a result is due this step
        logic row_lo;   // neighbour row above lies in the grid
        logic row_hi;   // neighbour row below lies in the grid
        logic col_lo;
        logic col_hi;
    } mws_ctl_t;

endpackage

[hw/rtl/mws_fifo.sv]
// ----------------------------------------------------------------------------
// mws_fifo
// Small register queue with a full and an empty flag; depth a power of two.
// ----------------------------------------------------------------------------
module mws_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hw/rtl/mws_front.sv]
// ----------------------------------------------------------------------------
// mws_front
// Tracks the raster position, classifies each beat and queues a step command.
// ----------------------------------------------------------------------------
module mws_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int SPEED_BITS = 16,
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             mode,
    input  logic signed [SPEED_BITS-1:0]     speed_in,
    input  logic                             good,
    input  logic [mws_pkg::WEIGHT_W-1:0]     weight,
    input  logic [mws_pkg::DIM_W-1:0]        grid_cols,
    input  logic [mws_pkg::DIM_W-1:0]        grid_rows,
    input  logic                             q_full,
    output logic                             q_wr,
    output mws_pkg::mws_ctl_t                q_ctl,
    output logic signed [SPEED_BITS-1:0]     q_speed,
    output logic [mws_pkg::WEIGHT_W-1:0]     q_weight,
    output logic                             q_rpar,
    output logic [CW-1:0]                    q_col,
    output logic [mws_pkg::POS_W-1:0]        q_er,
    output logic [CW-1:0]                    q_ec
);

    localparam int CIW = $clog2(MAX_COLS + 1);
    localparam int RIW = $clog2(MAX_ROWS + 2);
    localparam int RX  = RIW + 1;
    localparam int EW  = $clog2(MAX_ROWS * MAX_COLS + 1);

    logic [CIW-1:0] in_col_reg;
    logic [RIW-1:0] in_row_reg;
    logic [EW-1:0]  emit_reg;

    logic [CIW-1:0] cols_eff;
    logic [RIW-1:0] rows_eff;
    logic [RX-1:0]  rows_x;
    logic           wrap;
    logic [CIW-1:0] c0;
    logic [RX-1:0]  r0;
    logic           in_grid;
    logic           ignore;
    logic           flush_e;
    logic           main_e;
    logic [RX-1:0]  er;
    logic [CIW-1:0] ec;
    logic [CIW-1:0] c1;
    logic           col_end;
    logic [CIW-1:0] c1n;
    logic [RX-1:0]  r1;
    logic [EW-1:0]  emit_next;
    logic [EW-1:0]  frame_size;
    logic           done;
    logic           accept;
    logic [RX+mws_pkg::POS_W-1:0] er_pad;

    always_comb
    begin
        cols_eff = (grid_cols == '0) ? CIW'(1) :
                   (32'(grid_cols) > 32'(MAX_COLS)) ? CIW'(MAX_COLS) : CIW'(grid_cols);
        rows_eff = (grid_rows == '0) ? RIW'(1) :
                   (32'(grid_rows) > 32'(MAX_ROWS)) ? RIW'(MAX_ROWS) : RIW'(grid_rows);
        rows_x   = RX'(rows_eff);

        // a column count lowered mid-frame wraps the position at once
        wrap    = (in_col_reg >= cols_eff);
        c0      = wrap ? '0 : in_col_reg;
        r0      = wrap ? (RX'(in_row_reg) + RX'(1)) : RX'(in_row_reg);
        in_grid = (r0 < rows_x);
        ignore  = in_grid && mode;

        flush_e = (c0 == '0) && (r0 >= RX'(2)) && ((r0 - RX'(2)) < rows_x);
        main_e  = (c0 != '0) && (r0 >= RX'(1)) && ((r0 - RX'(1)) < rows_x);
        er      = flush_e ? (r0 - RX'(2)) : (r0 - RX'(1));
        ec      = flush_e ? (cols_eff - CIW'(1)) : (c0 - CIW'(1));

        c1      = c0 + CIW'(1);
        col_end = (c1 >= cols_eff);
        c1n     = col_end ? '0 : c1;
        r1      = col_end ? (r0 + RX'(1)) : r0;

        emit_next  = emit_reg + EW'(flush_e || main_e);
        frame_size = EW'(rows_eff) * EW'(cols_eff);
        done = (emit_next >= frame_size) || (r1 > (rows_x + RX'(1))) ||
               ((r1 == (rows_x + RX'(1))) && (c1n != '0));

        er_pad = {{mws_pkg::POS_W{1'b0}}, er};
    end

    assign accept = push && !q_full;
    assign full   = q_full;
    assign q_wr   = accept && !ignore;

    assign q_ctl.point  = in_grid && !mode;
    assign q_ctl.good   = good;
    assign q_ctl.emit   = flush_e || main_e;
    assign q_ctl.row_lo = (er != '0);
    assign q_ctl.row_hi = ((er + RX'(1)) < rows_x);
    assign q_ctl.col_lo = (ec != '0);
    assign q_ctl.col_hi = ((ec + CIW'(1)) < cols_eff);
    assign q_speed      = speed_in;
    assign q_weight     = weight;
    assign q_rpar       = r0[0];
    assign q_col        = c0[CW-1:0];
    assign q_er         = er_pad[mws_pkg::POS_W-1:0];
    assign q_ec         = ec[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            emit_reg   <= '0;
        end
        else if (accept)
        begin
            if (ignore)
            begin
                in_col_reg <= c0;
                in_row_reg <= RIW'(r0);
            end
            else if (done)
            begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                emit_reg   <= '0;
            end
            else
            begin
                in_col_reg <= c1n;
                in_row_reg <= RIW'(r1);
                emit_reg   <= emit_next;
            end
        end
    end

endmodule

[hw/rtl/mws_back.sv]
// ----------------------------------------------------------------------------
// mws_back
// Sequencer that runs one step: line buffers, weighting, 3x3 window,
// masked sum and a rounded divide by the neighbour count.
// ----------------------------------------------------------------------------
module mws_back #(
    parameter int MAX_COLS   = 1024,
    parameter int SPEED_BITS = 16,
    localparam int CW = $clog2(MAX_COLS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mws_pkg::SCALE_W-1:0]      weight_scale,
    input  logic                             q_empty,
    output logic                             q_rd,
    input  mws_pkg::mws_ctl_t                q_ctl,
    input  logic signed [SPEED_BITS-1:0]     q_speed,
    input  logic [mws_pkg::WEIGHT_W-1:0]     q_weight,
    input  logic                             q_rpar,
    input  logic [CW-1:0]                    q_col,
    input  logic [mws_pkg::POS_W-1:0]        q_er,
    input  logic [CW-1:0]                    q_ec,
    input  logic                             o_full,
    output logic                             o_wr,
    output logic [mws_pkg::POS_W-1:0]        o_row,
    output logic [mws_pkg::POS_W-1:0]        o_col,
    output logic signed [SPEED_BITS-1:0]     o_speed
);

    localparam int S    = SPEED_BITS;
    localparam int AW   = $clog2(2 * MAX_COLS);
    localparam int TW   = S + 17;               // weighted term
    localparam int SW   = TW + 4;               // sum of nine terms
    localparam int DW   = SW + 1 - mws_pkg::Q_SHIFT;
    localparam int DCW  = $clog2(DW + 1);
    localparam int PW1  = mws_pkg::WEIGHT_W + mws_pkg::SCALE_W;
    localparam int PW2  = S + 18;
    localparam int RW   = mws_pkg::RATIO_W;
    localparam int NW   = mws_pkg::CNT_W;
    localparam logic [RW-1:0] RATIO_ONE = RW'(1) << mws_pkg::Q_SHIFT;
    localparam logic [DW-1:0] HALF      = DW'(1) << (S - 1);
    localparam logic [DW-1:0] HI        = HALF - DW'(1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SAT   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    mws_pkg::mws_ctl_t           ctl_reg;
    logic signed [S-1:0]         spd_reg;
    logic [mws_pkg::WEIGHT_W-1:0] wgt_reg;
    logic                        rpar_reg;
    logic [CW-1:0]               col_reg;
    logic [mws_pkg::POS_W-1:0]   er_reg;
    logic [CW-1:0]               ec_reg;

    logic [TW:0]         wmem [2 * MAX_COLS];
    logic [S-1:0]        rmem [2 * MAX_COLS];
    logic [TW:0]         wa_reg;
    logic [TW:0]         wb_reg;
    logic [S-1:0]        raw_reg;
    logic [PW1-1:0]      prod1_reg;
    logic [TW-1:0]       term_reg;

    logic [TW-1:0]       wt_reg [3][3];
    logic                wg_reg [3][3];

    logic [1:0]          dr_reg;
    logic [1:0]          dc_reg;
    logic signed [SW-1:0] sum_reg;
    logic [NW-1:0]       cnt_reg;
    logic [DW-1:0]       dvd_reg;
    logic [NW-1:0]       rem_reg;
    logic [DCW-1:0]      bit_reg;
    logic                neg_reg;
    logic signed [S-1:0] res_reg;

    logic [AW-1:0]       addr_own;
    logic [AW-1:0]       addr_oth;
    logic [AW-1:0]       addr_raw;
    logic [RW-1:0]       ratio;
    logic signed [PW2-1:0] prod2;
    logic                row_ok;
    logic                col_ok;
    logic                take;
    logic                acc_last;
    logic [SW-1:0]       mag;
    logic [SW:0]         dsum;
    logic [NW:0]         trial;
    logic                fits;
    logic [CW+mws_pkg::POS_W-1:0] ec_pad;

    always_comb
    begin
        addr_own = (rpar_reg ? AW'(MAX_COLS) : AW'(0)) + AW'(col_reg);
        addr_oth = (rpar_reg ? AW'(0) : AW'(MAX_COLS)) + AW'(col_reg);
        addr_raw = (er_reg[0] ? AW'(MAX_COLS) : AW'(0)) + AW'(ec_reg);

        ratio = (prod1_reg[PW1-1:mws_pkg::Q_SHIFT] > (PW1 - mws_pkg::Q_SHIFT)'(RATIO_ONE)) ?
                RATIO_ONE : prod1_reg[mws_pkg::Q_SHIFT +: RW];
        prod2 = PW2'(spd_reg) * $signed(PW2'(ratio));

        row_ok = (dr_reg == 2'd0) ? ctl_reg.row_lo :
                 (dr_reg == 2'd2) ? ctl_reg.row_hi : 1'b1;
        col_ok = (dc_reg == 2'd0) ? ctl_reg.col_lo :
                 (dc_reg == 2'd2) ? ctl_reg.col_hi : 1'b1;
        take     = wg_reg[dr_reg][dc_reg] && row_ok && col_ok;
        acc_last = (dr_reg == 2'd2) && (dc_reg == 2'd2);

        mag  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        // round half away from zero on the magnitude
        dsum = (SW+1)'(mag) + ((SW+1)'(cnt_reg) << (mws_pkg::Q_SHIFT - 1));

        trial = {rem_reg, dvd_reg[DW-1]};
        fits  = (trial >= (NW+1)'(cnt_reg));

        ec_pad = {{mws_pkg::POS_W{1'b0}}, ec_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_empty) state_next = S_RD;
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_SHIFT;
            S_SHIFT: state_next = ctl_reg.emit ? S_ACC : S_IDLE;
            S_ACC:
            begin
                if (acc_last)
                begin
                    state_next = wg_reg[1][1] ? S_PREP : S_OUT;
                end
            end
            S_PREP:  state_next = S_DIV;
            S_DIV:   if (bit_reg == DCW'(1)) state_next = S_SAT;
            S_SAT:   state_next = S_OUT;
            S_OUT:   if (!o_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_rd    = (state_reg == S_IDLE) && !q_empty;
    assign o_wr    = (state_reg == S_OUT) && !o_full;
    assign o_row   = er_reg;
    assign o_col   = ec_pad[mws_pkg::POS_W-1:0];
    assign o_speed = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    wt_reg[k][j] <= '0;
                    wg_reg[k][j] <= 1'b0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SHIFT)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    wt_reg[k][0] <= wt_reg[k][1];
                    wg_reg[k][0] <= wg_reg[k][1];
                    wt_reg[k][1] <= wt_reg[k][2];
                    wg_reg[k][1] <= wg_reg[k][2];
                end
                wt_reg[0][2] <= wa_reg[TW-1:0];
                wg_reg[0][2] <= wa_reg[TW];
                wt_reg[1][2] <= wb_reg[TW-1:0];
                wg_reg[1][2] <= wb_reg[TW];
                wt_reg[2][2] <= ctl_reg.point ? term_reg : '0;
                wg_reg[2][2] <= ctl_reg.point && ctl_reg.good;
            end
        end
    end

    // step command and datapath
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            ctl_reg  <= q_ctl;
            spd_reg  <= q_speed;
            wgt_reg  <= q_weight;
            rpar_reg <= q_rpar;
            col_reg  <= q_col;
            er_reg   <= q_er;
            ec_reg   <= q_ec;
        end
        if (state_reg == S_RD)
        begin
            prod1_reg <= PW1'(wgt_reg) * PW1'(weight_scale);
        end
        if (state_reg == S_MUL)
        begin
            term_reg <= prod2[TW-1:0];
        end
        if (state_reg == S_SHIFT)
        begin
            dr_reg  <= 2'd0;
            dc_reg  <= 2'd0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == S_ACC)
        begin
            if (take)
            begin
                sum_reg <= sum_reg + SW'($signed(wt_reg[dr_reg][dc_reg]));
                cnt_reg <= cnt_reg + NW'(1);
            end
            if (dc_reg == 2'd2)
            begin
                dc_reg <= 2'd0;
                dr_reg <= dr_reg + 2'd1;
            end
            else
            begin
                dc_reg <= dc_reg + 2'd1;
            end
            if (acc_last && !wg_reg[1][1])
            begin
                res_reg <= raw_reg;
            end
        end
        if (state_reg == S_PREP)
        begin
            dvd_reg <= dsum[SW:mws_pkg::Q_SHIFT];
            neg_reg <= sum_reg[SW-1];
            rem_reg <= '0;
            bit_reg <= DCW'(DW);
        end
        if (state_reg == S_DIV)
        begin
            // restoring divide by the count, one quotient bit a cycle
            rem_reg <= fits ? NW'(trial - (NW+1)'(cnt_reg)) : trial[NW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], fits};
            bit_reg <= bit_reg - DCW'(1);
        end
        if (state_reg == S_SAT)
        begin
            if (neg_reg)
            begin
                res_reg <= (dvd_reg > HALF) ? S'(HALF) : S'(-dvd_reg);
            end
            else
            begin
                res_reg <= (dvd_reg > HI) ? S'(HI) : S'(dvd_reg);
            end
        end
    end

    // weighted line buffer: both rows read at the current column
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            wa_reg <= wmem[addr_own];
            wb_reg <= wmem[addr_oth];
        end
        if ((state_reg == S_SHIFT) && ctl_reg.point)
        begin
            wmem[addr_own] <= {ctl_reg.good, term_reg};
        end
    end

    // raw speed line buffer for pass-through of points that are not good
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            raw_reg <= rmem[addr_raw];
        end
        if ((state_reg == S_MUL) && ctl_reg.point)
        begin
            rmem[addr_own] <= spd_reg;
        end
    end

endmodule

[hw/rtl/masked_weighted_3x3_smoother_top.sv]
// ----------------------------------------------------------------------------
// masked_weighted_3x3_smoother_top
// Masked weighted 3x3 mean over a coarse grid streamed in raster order.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | beat
//  input     | in        | push / full            | mode, speed_in, good, weight
//  result    | out       | empty / pop            | out_row, out_col, speed_out
//  config    | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
//  a step that yields no result runs the read, multiply and shift states of the
//  back sequencer and returns to idle; a step with a good centre also sums the
//  nine window positions and divides by the count, one quotient bit a cycle;
//  a pass-through result skips the divide, and a full result queue adds stalls
//  a 4-deep command queue lets the front accept beats while the back works
//  reset clears position counters, window and queues; line buffers need none
// ----------------------------------------------------------------------------
module masked_weighted_3x3_smoother_top #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int SPEED_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mws_pkg::PADDR_W-1:0]   paddr,
    input  logic [mws_pkg::PDATA_W-1:0]   pwdata,
    output logic [mws_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic signed [SPEED_BITS-1:0]  speed_in,
    input  logic                          good,
    input  logic [mws_pkg::WEIGHT_W-1:0]  weight,
    output logic                          empty,
    input  logic                          pop,
    output logic [mws_pkg::POS_W-1:0]     out_row,
    output logic [mws_pkg::POS_W-1:0]     out_col,
    output logic signed [SPEED_BITS-1:0]  speed_out
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int CTL_W = $bits(mws_pkg::mws_ctl_t);
    localparam int CMD_W = CTL_W + SPEED_BITS + mws_pkg::WEIGHT_W + 1 + CW +
                           mws_pkg::POS_W + CW;
    localparam int RES_W = 2 * mws_pkg::POS_W + SPEED_BITS;

    logic [mws_pkg::DIM_W-1:0]   grid_cols_reg;
    logic [mws_pkg::DIM_W-1:0]   grid_rows_reg;
    logic [mws_pkg::SCALE_W-1:0] weight_scale_reg;

    logic                          cq_wr;
    logic                          cq_full;
    logic                          cq_rd;
    logic                          cq_empty;
    logic [CMD_W-1:0]              cq_wdata;
    logic [CMD_W-1:0]              cq_rdata;
    mws_pkg::mws_ctl_t             f_ctl;
    logic signed [SPEED_BITS-1:0]  f_speed;
    logic [mws_pkg::WEIGHT_W-1:0]  f_weight;
    logic                          f_rpar;
    logic [CW-1:0]                 f_col;
    logic [mws_pkg::POS_W-1:0]     f_er;
    logic [CW-1:0]                 f_ec;
    mws_pkg::mws_ctl_t             b_ctl;
    logic signed [SPEED_BITS-1:0]  b_speed;
    logic [mws_pkg::WEIGHT_W-1:0]  b_weight;
    logic                          b_rpar;
    logic [CW-1:0]                 b_col;
    logic [mws_pkg::POS_W-1:0]     b_er;
    logic [CW-1:0]                 b_ec;

    logic                          rq_wr;
    logic                          rq_full;
    logic [RES_W-1:0]              rq_rdata;
    logic [mws_pkg::POS_W-1:0]     r_row;
    logic [mws_pkg::POS_W-1:0]     r_col;
    logic signed [SPEED_BITS-1:0]  r_speed;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg    <= mws_pkg::COLS_RESET;
            grid_rows_reg    <= mws_pkg::ROWS_RESET;
            weight_scale_reg <= mws_pkg::SCALE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                mws_pkg::REG_COLS:  grid_cols_reg    <= pwdata[mws_pkg::DIM_W-1:0];
                mws_pkg::REG_ROWS:  grid_rows_reg    <= pwdata[mws_pkg::DIM_W-1:0];
                mws_pkg::REG_SCALE: weight_scale_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            mws_pkg::REG_COLS:  prdata = mws_pkg::PDATA_W'(grid_cols_reg);
            mws_pkg::REG_ROWS:  prdata = mws_pkg::PDATA_W'(grid_rows_reg);
            mws_pkg::REG_SCALE: prdata = weight_scale_reg;
            default:            prdata = '0;
        endcase
    end

    mws_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SPEED_BITS (SPEED_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .speed_in  (speed_in),
        .good      (good),
        .weight    (weight),
        .grid_cols (grid_cols_reg),
        .grid_rows (grid_rows_reg),
        .q_full    (cq_full),
        .q_wr      (cq_wr),
        .q_ctl     (f_ctl),
        .q_speed   (f_speed),
        .q_weight  (f_weight),
        .q_rpar    (f_rpar),
        .q_col     (f_col),
        .q_er      (f_er),
        .q_ec      (f_ec)
    );

    assign cq_wdata = {f_ctl, f_speed, f_weight, f_rpar, f_col, f_er, f_ec};
    assign {b_ctl, b_speed, b_weight, b_rpar, b_col, b_er, b_ec} = cq_rdata;

    mws_fifo #(
        .W     (CMD_W),
        .DEPTH (4)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cq_wr),
        .wdata (cq_wdata),
        .full  (cq_full),
        .rd    (cq_rd),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    mws_back #(
        .MAX_COLS   (MAX_COLS),
        .SPEED_BITS (SPEED_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .weight_scale (weight_scale_reg),
        .q_empty      (cq_empty),
        .q_rd         (cq_rd),
        .q_ctl        (b_ctl),
        .q_speed      (b_speed),
        .q_weight     (b_weight),
        .q_rpar       (b_rpar),
        .q_col        (b_col),
        .q_er         (b_er),
        .q_ec         (b_ec),
        .o_full       (rq_full),
        .o_wr         (rq_wr),
        .o_row        (r_row),
        .o_col        (r_col),
        .o_speed      (r_speed)
    );

    mws_fifo #(
        .W     (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rq_wr),
        .wdata ({r_row, r_col, r_speed}),
        .full  (rq_full),
        .rd    (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign {out_row, out_col, speed_out} = rq_rdata;

endmodule

[hw/rtl/mws_checker.sv]
// ----------------------------------------------------------------------------
// mws_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module mws_checker #(
    parameter int SPEED_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [mws_pkg::PADDR_W-1:0]   paddr,
    input logic [mws_pkg::PDATA_W-1:0]   pwdata,
    input logic [mws_pkg::PDATA_W-1:0]   prdata,
    input logic                          pready,
    input logic                          empty,
    input logic                          pop,
    input logic [mws_pkg::POS_W-1:0]     out_row,
    input logic [mws_pkg::POS_W-1:0]     out_col,
    input logic [SPEED_BITS-1:0]         speed_out
);

    // no result is offered on the edge after a reset edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // a waiting result beat holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_row) && $stable(out_col) &&
                              $stable(speed_out)))
        else $error("result beat changed before pop");

    // column count reads back what was written
    a_cols_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == mws_pkg::REG_COLS))
        ##1 (paddr[3:2] == mws_pkg::REG_COLS)
        |-> (prdata[mws_pkg::DIM_W-1:0] == $past(pwdata[mws_pkg::DIM_W-1:0])))
        else $error("grid_cols readback mismatch");

endmodule

bind masked_weighted_3x3_smoother_top mws_checker #(.SPEED_BITS(SPEED_BITS)) u_mws_checker (.*);
